>>> hdl/imtap_pkg.sv
// Shared types and constants for the im2col tap address generator.
// No dependencies.
`default_nettype none
package imtap_pkg;
	localparam int DIV_W = 24;   // column index width, divider width
	localparam int IDX_W = 24;   // row index field width
	localparam int DIM_W = 12;   // feature map dimension width
	localparam int KER_W = 4;    // kernel size / stride register width

	typedef enum logic [2:0] {
		REG_OUT_HEIGHT = 3'd0,
		REG_OUT_WIDTH  = 3'd1,
		REG_KERNEL_H   = 3'd2,
		REG_KERNEL_W   = 3'd3,
		REG_STRIDE     = 3'd4,
		REG_PAD        = 3'd5,
		REG_IN_HEIGHT  = 3'd6,
		REG_IN_WIDTH   = 3'd7
	} reg_idx_t;

	// static layer geometry handed to the tap sequencer
	typedef struct packed {
		logic [KER_W-1:0] kh_n;
		logic [KER_W-1:0] kw_n;
		logic [KER_W-1:0] stride;
		logic [2:0]       pad;
		logic [DIM_W-1:0] in_h;
		logic [DIM_W-1:0] in_w;
		logic [IDX_W-1:0] plane_in;
	} geom_t;
endpackage
`default_nettype wire

>>> hdl/imtap_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on imtap_pkg.
`default_nettype none
module imtap_div #(
	parameter int PW = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_v,
	input  wire logic [imtap_pkg::DIV_W-1:0] in_n,
	input  wire logic [PW-1:0]               in_p,
	input  wire logic [imtap_pkg::DIV_W-1:0] divisor,
	output logic                             out_v,
	output logic      [imtap_pkg::DIV_W-1:0] out_q,
	output logic      [imtap_pkg::DIV_W-1:0] out_r,
	output logic      [PW-1:0]               out_p
);
	localparam int W = imtap_pkg::DIV_W;

	logic         v_s [0:W];
	logic [W-1:0] n_s [0:W];
	logic [W-1:0] r_s [0:W];
	logic [W-1:0] q_s [0:W];
	logic [PW-1:0] p_s [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= in_n;
			r_s[0] <= '0;
			q_s[0] <= '0;
			p_s[0] <= in_p;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [W:0]   sh;
		logic         ge;
		logic [W:0]   diff;
		always_comb begin
			sh   = {r_s[k-1], n_s[k-1][W-1]};
			diff = sh - {1'b0, divisor};
			ge   = (sh >= {1'b0, divisor});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= {n_s[k-1][W-2:0], 1'b0};
				r_s[k] <= ge ? diff[W-1:0] : sh[W-1:0];
				q_s[k] <= {q_s[k-1][W-2:0], ge};
				p_s[k] <= p_s[k-1];
			end
		end
	end

	assign out_v = v_s[W];
	assign out_q = q_s[W];
	assign out_r = r_s[W];
	assign out_p = p_s[W];
endmodule
`default_nettype wire

>>> hdl/imtap_seq.sv
// Column prep, kernel tap sequencer and three-stage tap address pipeline.
// Depends on imtap_pkg.
`default_nettype none
module imtap_seq #(
	parameter int IDX_BITS = 24
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire imtap_pkg::geom_t            geom,
	input  wire logic                        col_v,
	output logic                             col_take,
	input  wire logic [imtap_pkg::IDX_W-1:0] batch,
	input  wire logic [imtap_pkg::DIM_W-1:0] orow,
	input  wire logic [imtap_pkg::DIM_W-1:0] ocol,
	input  wire logic                        last_col,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [imtap_pkg::IDX_W-1:0] row_index,
	output logic                             in_bounds,
	output logic                             last_tap,
	output logic                             tile_end
);
	localparam int IW = imtap_pkg::IDX_W;
	localparam int DW = imtap_pkg::DIM_W;
	localparam int KW = imtap_pkg::KER_W;
	localparam int SW = DW + KW;
	localparam logic [IW-1:0] IDX_MASK =
		(IDX_BITS >= IW) ? {IW{1'b1}} : IW'((64'd1 << IDX_BITS) - 64'd1);

	// prep stage
	logic          v_s1;
	logic [IW-1:0] base_s1;
	logic [SW-1:0] orow_s1, ocol_s1;
	logic          last_s1;
	// sequencer
	logic          busy_q;
	logic [KW-1:0] kh_q, kw_q;
	logic [IW-1:0] base_q;
	logic [SW-1:0] orow_q, ocol_q;
	logic          last_q;
	// tap pipeline
	logic          v_s2, v_s3, v_s4;
	logic          ins_s2, ins_s3;
	logic [DW-1:0] ih_s2, iw_s2;
	logic [IW-1:0] base_s2;
	logic          fin_s2, fin_s3, tile_s2, tile_s3;
	logic [IW-1:0] prod_s3, sum_s3;

	logic en1, en2, en3, emit, fin, ld, prep_en, nonzero;
	logic signed [SW+1:0] ih, iw;
	logic [2*IW-1:0] bprod;

	assign en3  = !v_s4 || out_ready;
	assign en2  = !v_s3 || en3;
	assign en1  = !v_s2 || en2;
	assign emit = busy_q && en1;
	assign fin  = (kh_q == geom.kh_n - KW'(1)) && (kw_q == geom.kw_n - KW'(1));
	assign ld   = v_s1 && (!busy_q || (emit && fin));
	assign prep_en  = !v_s1 || ld;
	assign col_take = prep_en;
	assign nonzero  = (geom.kh_n != '0) && (geom.kw_n != '0);
	assign bprod    = (2*IW)'(batch) * (2*IW)'(geom.plane_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (prep_en) begin
			v_s1 <= col_v;
		end
	end

	always_ff @(posedge clk) begin
		if (prep_en) begin
			base_s1 <= bprod[IW-1:0];
			orow_s1 <= SW'(orow) * SW'(geom.stride);
			ocol_s1 <= SW'(ocol) * SW'(geom.stride);
			last_s1 <= last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kh_q   <= '0;
			kw_q   <= '0;
		end else if (ld) begin
			busy_q <= nonzero;
			kh_q   <= '0;
			kw_q   <= '0;
		end else if (emit) begin
			if (fin) begin
				busy_q <= 1'b0;
			end
			if (kw_q == geom.kw_n - KW'(1)) begin
				kw_q <= '0;
				kh_q <= kh_q + KW'(1);
			end else begin
				kw_q <= kw_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			base_q <= base_s1;
			orow_q <= orow_s1;
			ocol_q <= ocol_s1;
			last_q <= last_s1;
		end
	end

	// input position of the current tap
	always_comb begin
		ih = $signed({2'b00, orow_q}) + $signed({{(SW-KW+2){1'b0}}, kh_q})
			- $signed({{(SW-1){1'b0}}, geom.pad});
		iw = $signed({2'b00, ocol_q}) + $signed({{(SW-KW+2){1'b0}}, kw_q})
			- $signed({{(SW-1){1'b0}}, geom.pad});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s2 <= emit;
			if (en2) v_s3 <= v_s2;
			if (en3) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ins_s2  <= !ih[SW+1] && !iw[SW+1] &&
				(ih[SW:0] < {{(SW-DW+1){1'b0}}, geom.in_h}) &&
				(iw[SW:0] < {{(SW-DW+1){1'b0}}, geom.in_w});
			ih_s2   <= ih[DW-1:0];
			iw_s2   <= iw[DW-1:0];
			base_s2 <= base_q;
			fin_s2  <= fin;
			tile_s2 <= fin && last_q;
		end
		if (en2) begin
			prod_s3 <= IW'(ih_s2) * IW'(geom.in_w);
			sum_s3  <= base_s2 + {{(IW-DW){1'b0}}, iw_s2};
			ins_s3  <= ins_s2;
			fin_s3  <= fin_s2;
			tile_s3 <= tile_s2;
		end
		if (en3) begin
			row_index <= ins_s3 ? ((prod_s3 + sum_s3) & IDX_MASK) : '0;
			in_bounds <= ins_s3;
			last_tap  <= fin_s3;
			tile_end  <= tile_s3;
		end
	end

	assign out_valid = v_s4;
endmodule
`default_nettype wire

>>> hdl/im2col_tap_address_generator_core.sv
// im2col tap address generator, top level: config registers, two divider
// pipelines and the tap sequencer. Depends on imtap_pkg, imtap_div, imtap_seq.
//
// Usage:
//  - s_* channel: one transaction per output column; s_tdata holds
//    column_index, s_tlast marks the last column of a tile.
//  - m_* channel: one transaction per kernel tap, kh outer, kw inner.
//    m_tdata = row_index, m_tuser = {last_tap, in_bounds}, m_tlast = tile_end.
//  - cfg_*: register writes (index 0..7), always ready; write only when idle.
//  - Path: both divider pipelines, then prep, sequencer and three tap stages.
//  - Throughput: one tap per cycle unless the receiver stalls, set by the
//    single tap sequencer; a column yields kh*kw taps (nine for a 3x3 kernel).
//    Columns stream into the divider pipelines every cycle while the sequencer
//    is busy until they fill.
//  - Reset clears all valid bits and loads register reset values.
//  - A receiver stall freezes the tap stages, then the sequencer, then the
//    divider pipelines and s_tready; nothing is lost or repeated.
`default_nettype none
module im2col_tap_address_generator_core #(
	parameter int MAX_KERNEL = 8,
	parameter int INDEX_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [23:0] column_index
	input  wire logic        s_tlast,   // last_column
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [23:0] row_index
	output logic      [1:0]  m_tuser,   // [0] in_bounds, [1] last_tap
	output logic             m_tlast,   // tile_end
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	localparam int DW = imtap_pkg::DIM_W;
	localparam int KW = imtap_pkg::KER_W;
	localparam int IW = imtap_pkg::IDX_W;
	localparam logic [KW-1:0] KMAX = KW'(MAX_KERNEL);

	logic [DW-1:0] out_h_q, out_w_q, in_h_q, in_w_q;
	logic [KW-1:0] ker_h_q, ker_w_q, stride_q;
	logic [2:0]    pad_q;
	logic [IW-1:0] plane_out_q, plane_in_q;
	logic [DW-1:0] oh_sz, ow_sz;
	logic [2*DW-1:0] pout, pin;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_h_q  <= DW'(1);
			out_w_q  <= DW'(1);
			ker_h_q  <= KW'(3);
			ker_w_q  <= KW'(3);
			stride_q <= KW'(1);
			pad_q    <= 3'd1;
			in_h_q   <= DW'(1);
			in_w_q   <= DW'(1);
		end else if (cfg_valid && cfg_index[7:3] == '0) begin
			unique case (imtap_pkg::reg_idx_t'(cfg_index[2:0]))
				imtap_pkg::REG_OUT_HEIGHT: out_h_q  <= cfg_data;
				imtap_pkg::REG_OUT_WIDTH:  out_w_q  <= cfg_data;
				imtap_pkg::REG_KERNEL_H:   ker_h_q  <= cfg_data[KW-1:0];
				imtap_pkg::REG_KERNEL_W:   ker_w_q  <= cfg_data[KW-1:0];
				imtap_pkg::REG_STRIDE:     stride_q <= cfg_data[KW-1:0];
				imtap_pkg::REG_PAD:        pad_q    <= cfg_data[2:0];
				imtap_pkg::REG_IN_HEIGHT:  in_h_q   <= cfg_data;
				imtap_pkg::REG_IN_WIDTH:   in_w_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero output size counts as one
	assign oh_sz = (out_h_q == '0) ? DW'(1) : out_h_q;
	assign ow_sz = (out_w_q == '0) ? DW'(1) : out_w_q;
	assign pout  = (2*DW)'(oh_sz) * (2*DW)'(ow_sz);
	assign pin   = (2*DW)'(in_h_q) * (2*DW)'(in_w_q);

	// plane sizes registered; user keeps config static while items are in flight
	always_ff @(posedge clk) begin
		plane_out_q <= pout[IW-1:0];
		plane_in_q  <= pin[IW-1:0];
	end

	imtap_pkg::geom_t geom;
	always_comb begin
		geom.kh_n     = (ker_h_q > KMAX) ? KMAX : ker_h_q;
		geom.kw_n     = (ker_w_q > KMAX) ? KMAX : ker_w_q;
		geom.stride   = stride_q;
		geom.pad      = pad_q;
		geom.in_h     = in_h_q;
		geom.in_w     = in_w_q;
		geom.plane_in = plane_in_q;
	end

	// column -> batch, remainder -> row, col
	logic          adv, col_take;
	logic          d1_v, d2_v;
	logic [IW-1:0] d1_q, d1_r, d2_q, d2_r;
	logic          d1_p;
	logic [IW:0]   d2_p;

	assign adv      = !d2_v || col_take;
	assign s_tready = adv;

	imtap_div #(.PW(1)) u_div_plane (
		.clk, .arst_n, .en(adv),
		.in_v(s_tvalid), .in_n(s_tdata), .in_p(s_tlast),
		.divisor(plane_out_q),
		.out_v(d1_v), .out_q(d1_q), .out_r(d1_r), .out_p(d1_p)
	);

	imtap_div #(.PW(IW+1)) u_div_row (
		.clk, .arst_n, .en(adv),
		.in_v(d1_v), .in_n(d1_r), .in_p({d1_q, d1_p}),
		.divisor({{(IW-DW){1'b0}}, ow_sz}),
		.out_v(d2_v), .out_q(d2_q), .out_r(d2_r), .out_p(d2_p)
	);

	logic in_bounds, last_tap;

	imtap_seq #(.IDX_BITS(INDEX_BITS)) u_seq (
		.clk, .arst_n, .geom,
		.col_v(d2_v), .col_take,
		.batch(d2_p[IW:1]), .orow(d2_q[DW-1:0]), .ocol(d2_r[DW-1:0]),
		.last_col(d2_p[0]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.row_index(m_tdata), .in_bounds, .last_tap, .tile_end(m_tlast)
	);

	assign m_tuser = {last_tap, in_bounds};

	// tile end only rides on the final tap of a column
	a_tile_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("tile_end without last_tap");

	// padding taps carry a zero index
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("out-of-bounds tap with nonzero index");
endmodule
`default_nettype wire

>>> tb/tb_im2col_tap_address_generator_core.sv
// Self-checking testbench for im2col_tap_address_generator_core: a tap predictor,
// a table of directed columns, then random columns under several layer settings.
// Depends on imtap_pkg and the core RTL.
`default_nettype none
module tb_im2col_tap_address_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 200;   // well above the column-to-tap latency

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	im2col_tap_address_generator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one expected kernel tap transaction
	typedef struct {
		logic [23:0] row_index;
		logic        in_bounds;
		logic        last_tap;
		logic        tile_end;
	} tap_t;

	tap_t tap_q[$];
	int   errors = 0;
	int   cycles = 0;
	int   cols_sent = 0;
	int   snd_idle = 38;
	int   rcv_idle = 81;
	int   stall_req = 0;
	int   hold_left = 0;

	// shadow copy of the layer registers, reset values
	logic [imtap_pkg::DIM_W-1:0] sh_out_h = 12'd1, sh_out_w = 12'd1;
	logic [imtap_pkg::DIM_W-1:0] sh_in_h = 12'd1, sh_in_w = 12'd1;
	logic [imtap_pkg::KER_W-1:0] sh_ker_h = 4'd3, sh_ker_w = 4'd3, sh_stride = 4'd1;
	logic [2:0]                  sh_pad = 3'd1;

	// Tap list for one column: divide into batch/row/col, walk kh outer, kw inner.
	task automatic predict_taps(input logic [23:0] col, input logic last);
		longint unsigned oh_sz, ow_sz, plane, batch, orow, ocol, kh_n, kw_n, base, idx;
		longint ih, iw;
		tap_t t;
		int n, total;
		oh_sz = (sh_out_h == 0) ? 1 : sh_out_h;
		ow_sz = (sh_out_w == 0) ? 1 : sh_out_w;
		plane = oh_sz * ow_sz;
		batch = col / plane;
		orow  = (col % plane) / ow_sz;
		ocol  = col % ow_sz;
		kh_n  = (sh_ker_h > 8) ? 8 : sh_ker_h;  // oversized kernel saturates
		kw_n  = (sh_ker_w > 8) ? 8 : sh_ker_w;
		base  = batch * sh_in_h * sh_in_w;
		total = int'(kh_n * kw_n);
		n = 0;
		for (int kh = 0; kh < kh_n; kh++) begin
			for (int kw = 0; kw < kw_n; kw++) begin
				ih = longint'(orow * sh_stride + kh) - longint'(sh_pad);
				iw = longint'(ocol * sh_stride + kw) - longint'(sh_pad);
				t.in_bounds = (ih >= 0 && iw >= 0 && ih < sh_in_h && iw < sh_in_w);
				idx = base + longint'(ih) * sh_in_w + longint'(iw);
				t.row_index = t.in_bounds ? idx[23:0] : 24'd0;
				n++;
				t.last_tap = (n == total);
				t.tile_end = (n == total) ? last : 1'b0;
				tap_q.push_back(t);
			end
		end
	endtask

	// idle mix follows the column count: sender light / receiver heavy,
	// then the reverse, then no idling at all
	task automatic send_col(input logic [23:0] col, input logic last, input bit known,
			input logic [23:0] ctr);
		tap_t t;
		snd_idle = (cols_sent < 55) ? 38 : (cols_sent < 110) ? 81 : 0;
		rcv_idle = (cols_sent < 55) ? 81 : (cols_sent < 110) ? 38 : 0;
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = col;
		s_tlast  = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		cols_sent++;
		if (known) begin
			// reset layer: 3x3 over a 1x1 input, only the center tap hits
			for (int k = 0; k < 9; k++) begin
				t.row_index = (k == 4) ? ctr : 24'd0;
				t.in_bounds = (k == 4);
				t.last_tap  = (k == 8);
				t.tile_end  = (k == 8) ? last : 1'b0;
				tap_q.push_back(t);
			end
		end else begin
			predict_taps(col, last);
		end
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [7:0] idx, input logic [11:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < 8) begin
			case (imtap_pkg::reg_idx_t'(idx[2:0]))
				imtap_pkg::REG_OUT_HEIGHT: sh_out_h = val;
				imtap_pkg::REG_OUT_WIDTH:  sh_out_w = val;
				imtap_pkg::REG_KERNEL_H:   sh_ker_h = val[3:0];
				imtap_pkg::REG_KERNEL_W:   sh_ker_w = val[3:0];
				imtap_pkg::REG_STRIDE:     sh_stride = val[3:0];
				imtap_pkg::REG_PAD:        sh_pad = val[2:0];
				imtap_pkg::REG_IN_HEIGHT:  sh_in_h = val;
				imtap_pkg::REG_IN_WIDTH:   sh_in_w = val;
			endcase
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_layer(input int oh, input int ow, input int kh, input int kw,
			input int st, input int pd, input int ih, input int iw);
		cfg_write(8'(imtap_pkg::REG_OUT_HEIGHT), 12'(oh));
		cfg_write(8'(imtap_pkg::REG_OUT_WIDTH), 12'(ow));
		cfg_write(8'(imtap_pkg::REG_KERNEL_H), 12'(kh));
		cfg_write(8'(imtap_pkg::REG_KERNEL_W), 12'(kw));
		cfg_write(8'(imtap_pkg::REG_STRIDE), 12'(st));
		cfg_write(8'(imtap_pkg::REG_PAD), 12'(pd));
		cfg_write(8'(imtap_pkg::REG_IN_HEIGHT), 12'(ih));
		cfg_write(8'(imtap_pkg::REG_IN_WIDTH), 12'(iw));
	endtask

	// mostly columns inside a few batches, some fully random 24-bit values
	task automatic random_cols(input int n);
		longint unsigned span;
		logic [23:0] col;
		for (int i = 0; i < n; i++) begin
			span = longint'((sh_out_h == 0) ? 1 : sh_out_h) *
				((sh_out_w == 0) ? 1 : sh_out_w) * 3;
			if (span > 24'hFFFFFF) span = 24'hFFFFFF;
			col = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
				24'($urandom_range(0, int'(span - 1)));
			send_col(col, 1'($urandom_range(0, 1)), 1'b0, 24'd0);
		end
		s_tvalid = 1'b0;
	endtask

	// wait out every expected tap, then the pipeline depth for columns
	// that produce nothing
	task automatic drain();
		while (tap_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	typedef struct {
		logic [23:0] col;
		logic        last;
		logic [23:0] ctr;   // expected center-tap index under the reset layer
	} dir_row_t;

	dir_row_t dir_tbl[6] = '{
		'{24'd0,        1'b0, 24'd0},
		'{24'hFFFFFF,   1'b1, 24'hFFFFFF},
		'{24'd1,        1'b1, 24'd1},
		'{24'hAAAAAA,   1'b0, 24'hAAAAAA},
		'{24'h555555,   1'b1, 24'h555555},
		'{24'd4095,     1'b0, 24'd4095}
	};

	// receiver: random ready, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_req != 0) begin
			hold_left = 400;
			stall_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	// tap checker: compare against the oldest expectation
	always @(posedge clk) begin
		tap_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (tap_q.size() == 0) begin
				$error("unexpected tap transaction: row_index %0h", m_tdata);
				errors++;
			end else begin
				e = tap_q.pop_front();
				if (m_tdata !== e.row_index) begin
					$error("row_index: expected %0h, got %0h", e.row_index, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== e.in_bounds) begin
					$error("in_bounds: expected %0b, got %0b", e.in_bounds, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.last_tap) begin
					$error("last_tap: expected %0b, got %0b", e.last_tap, m_tuser[1]);
					errors++;
				end
				if (m_tlast !== e.tile_end) begin
					$error("tile_end: expected %0b, got %0b", e.tile_end, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset layer, expectations read straight off the table
		foreach (dir_tbl[i])
			send_col(dir_tbl[i].col, dir_tbl[i].last, 1'b1, dir_tbl[i].ctr);
		s_tvalid = 1'b0;
		drain();

		// ordinary 3x3 conv; out-of-range register writes must be dropped
		set_layer(4, 5, 3, 3, 1, 1, 4, 5);
		cfg_write(8'd8, 12'hFFF);
		cfg_write(8'd255, 12'h000);
		stall_req = 1;
		random_cols(45);
		drain();

		// largest geometry, 8x8 kernel, index wraps
		set_layer(4095, 4095, 8, 8, 15, 7, 4095, 4095);
		random_cols(6);
		drain();

		// zero output size, oversized kernel, zero stride, zero input height
		set_layer(0, 0, 15, 2, 0, 0, 0, 3);
		random_cols(20);
		drain();

		// zero kernel height: columns produce no taps
		set_layer(7, 3, 0, 3, 2, 1, 9, 9);
		random_cols(8);
		drain();

		// zero kernel width and zero input width
		set_layer(3, 3, 2, 0, 1, 0, 5, 0);
		random_cols(4);
		drain();

		// 1x1 kernel, no padding: row index equals batch-scaled position
		set_layer(1, 1, 1, 1, 1, 0, 1, 1);
		random_cols(30);
		drain();

		// strided conv with padding on a larger map
		set_layer(16, 16, 3, 3, 2, 1, 32, 32);
		random_cols(40);
		drain();

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
hdl/imtap_pkg.sv
hdl/imtap_div.sv
hdl/imtap_seq.sv
hdl/im2col_tap_address_generator_core.sv
tb/tb_im2col_tap_address_generator_core.sv
